>>> design/gprc_pkg.sv
// ----------------------------------------------------------------------------
// gprc_pkg
// Shared types and constants of the gated pulse-rate classifier: register
// indexes, counter widths and the structs passed between its modules.
// ----------------------------------------------------------------------------
package gprc_pkg;

   // Field and counter widths.
   localparam int WinW     = 24;   // window counters and window_ticks
   localparam int ScanW    = 28;   // scan total
   localparam int IdxW     = 4;    // window index
   localparam int NumWinW  = 5;    // num_windows register
   localparam int DebW     = 8;    // debounce_ticks register
   localparam int RateW    = 16;   // rate_a and rate_b
   localparam int ConfW    = 7;    // confidence in percent
   localparam int SinceW   = 9;    // ticks since last accepted edge
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 24;

   localparam int MaxWindows = 16;

   // Distance |2*total - a - b| and its product with 100.
   localparam int DistW = ScanW + 1;
   localparam int RemW  = DistW + ConfW;

   // Confidence ceiling.
   localparam logic [ConfW-1:0] ConfMax = ConfW'(100);

   // Register indexes of the configuration port.
   localparam logic [CsrIdxW-1:0] CSR_WINDOW_TICKS     = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_NUM_WINDOWS      = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_DEBOUNCE_TICKS   = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_RATE_A           = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_RATE_B           = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_LOW_CONF_PERCENT = 3'd5;

   // Counter settings taken from the register file.
   typedef struct packed {
      logic [WinW-1:0]    window_ticks;
      logic [NumWinW-1:0] num_windows;
      logic [DebW-1:0]    debounce_ticks;
   } cnt_cfg_type;

   // What the current tick does to the scan.
   typedef struct packed {
      logic              win_done;
      logic              scan_done;
      logic [IdxW-1:0]   win_index;
      logic [WinW-1:0]   win_count;
      logic [ScanW-1:0]  scan_total;
   } tick_info_type;

   // Classifier request and result.
   typedef struct packed {
      logic              start;
      logic [ScanW-1:0]  total;
      logic [RateW-1:0]  rate_a;
      logic [RateW-1:0]  rate_b;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic              is_class_a;
      logic [ConfW-1:0]  confidence;
   } div_rsp_type;

endpackage

>>> design/gprc_counter.sv
// ----------------------------------------------------------------------------
// gprc_counter
// Edge debounce and window/scan counting. The tick outcome is combinational
// from the current state and the incoming transaction; state advances when
// the tick is accepted.
// ----------------------------------------------------------------------------
module gprc_counter import gprc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          tick,
   input  logic          falling_edge,
   input  logic          start_scan,
   input  cnt_cfg_type   cfg,
   output tick_info_type info
);

   logic               scanning_ff;
   logic [WinW-1:0]    tick_in_window_ff;
   logic [IdxW-1:0]    window_number_ff;
   logic [WinW-1:0]    edges_in_window_ff;
   logic [ScanW-1:0]   edges_in_scan_ff;
   logic [SinceW-1:0]  since_edge_ff;

   logic [SinceW-1:0]  since_edge_in;
   logic               edge_ok;
   logic               fresh;
   logic               active;
   logic [WinW-1:0]    tiw_base;
   logic [IdxW-1:0]    wn_base;
   logic [WinW-1:0]    ew_base;
   logic [ScanW-1:0]   es_base;
   logic [WinW-1:0]    tiw_in;
   logic [WinW-1:0]    ew_in;
   logic [ScanW-1:0]   es_in;
   logic [WinW-1:0]    wt_eff;
   logic [NumWinW-1:0] nw_eff;
   logic [NumWinW-1:0] wn_next;

   // Debounce: saturating age of the last accepted edge.
   always_comb begin
      since_edge_in = since_edge_ff;
      if (since_edge_ff < SinceW'(256)) begin
         since_edge_in = since_edge_ff + SinceW'(1);
      end
      edge_ok = falling_edge && (since_edge_in > {1'b0, cfg.debounce_ticks});
   end

   // A start while idle clears the counters and counts as window 0's first tick.
   assign fresh    = !scanning_ff && start_scan;
   assign active   = scanning_ff || start_scan;
   assign tiw_base = fresh ? '0 : tick_in_window_ff;
   assign wn_base  = fresh ? '0 : window_number_ff;
   assign ew_base  = fresh ? '0 : edges_in_window_ff;
   assign es_base  = fresh ? '0 : edges_in_scan_ff;

   // Saturating edge counts and the tick position.
   always_comb begin
      ew_in = ew_base;
      es_in = es_base;
      if (edge_ok && (ew_base != '1)) begin
         ew_in = ew_base + WinW'(1);
      end
      if (edge_ok && (es_base != '1)) begin
         es_in = es_base + ScanW'(1);
      end
      tiw_in = tiw_base + WinW'(1);
   end

   // Effective window length and count.
   always_comb begin
      wt_eff = (cfg.window_ticks == '0) ? WinW'(1) : cfg.window_ticks;
      if (cfg.num_windows == '0) begin
         nw_eff = NumWinW'(1);
      end else if (cfg.num_windows > NumWinW'(MaxWindows)) begin
         nw_eff = NumWinW'(MaxWindows);
      end else begin
         nw_eff = cfg.num_windows;
      end
      wn_next = {1'b0, wn_base} + NumWinW'(1);
   end

   assign info.win_done   = active && (tiw_in >= wt_eff);
   assign info.scan_done  = info.win_done && (wn_next >= nw_eff);
   assign info.win_index  = wn_base;
   assign info.win_count  = ew_in;
   assign info.scan_total = es_in;

   // State update on an accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         scanning_ff        <= 1'b0;
         tick_in_window_ff  <= '0;
         window_number_ff   <= '0;
         edges_in_window_ff <= '0;
         edges_in_scan_ff   <= '0;
         since_edge_ff      <= '0;
      end else if (tick) begin
         since_edge_ff <= edge_ok ? '0 : since_edge_in;
         if (active) begin
            edges_in_scan_ff <= es_in;
            if (info.win_done) begin
               tick_in_window_ff  <= '0;
               edges_in_window_ff <= '0;
               if (info.scan_done) begin
                  scanning_ff      <= 1'b0;
                  window_number_ff <= '0;
               end else begin
                  scanning_ff      <= 1'b1;
                  window_number_ff <= wn_next[IdxW-1:0];
               end
            end else begin
               scanning_ff        <= 1'b1;
               tick_in_window_ff  <= tiw_in;
               edges_in_window_ff <= ew_in;
            end
         end
      end
   end

   // The edge age never passes its saturation point.
   a_since_sat: assert property (@(posedge clock) disable iff (reset)
      since_edge_ff <= SinceW'(256))
      else $error("edge age beyond saturation");

endmodule

>>> design/gprc_divider.sv
// ----------------------------------------------------------------------------
// gprc_divider
// Classifier: picks the nearer rate and computes the confidence
// min(100, |2t-a-b|*100/|a-b|) with one shared compare/subtract unit,
// one restoring quotient bit per cycle.
// ----------------------------------------------------------------------------
module gprc_divider import gprc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   typedef enum logic [1:0] {D_IDLE, D_MUL, D_DIV, D_DONE} div_state_type;

   div_state_type     state_ff;
   logic [DistW-1:0]  dist_ff;
   logic [RateW-1:0]  span_ff;
   logic [RemW-1:0]   rem_ff;
   logic [ConfW-1:0]  quo_ff;
   logic [2:0]        step_ff;
   logic              is_a_ff;
   logic [ConfW-1:0]  conf_ff;

   logic [DistW-1:0]  twice_total;
   logic [DistW-1:0]  rate_sum;
   logic [DistW-1:0]  dist_in;
   logic [ScanW-1:0]  dist_a;
   logic [ScanW-1:0]  dist_b;
   logic [RemW-1:0]   shifted;
   logic              ge;
   logic [ConfW:0]    bit_mask;
   logic [ConfW-1:0]  quo_in;

   // Distances computed once when a request arrives.
   always_comb begin
      twice_total = {req.total, 1'b0};
      rate_sum    = DistW'(req.rate_a) + DistW'(req.rate_b);
      dist_in     = (twice_total >= rate_sum) ? twice_total - rate_sum
                                              : rate_sum - twice_total;
      dist_a = (req.total >= ScanW'(req.rate_a)) ? req.total - ScanW'(req.rate_a)
                                                 : ScanW'(req.rate_a) - req.total;
      dist_b = (req.total >= ScanW'(req.rate_b)) ? req.total - ScanW'(req.rate_b)
                                                 : ScanW'(req.rate_b) - req.total;
   end

   // Shared compare/subtract against the shifted span.
   always_comb begin
      shifted  = RemW'(span_ff) << step_ff;
      ge       = rem_ff >= shifted;
      bit_mask = (ConfW+1)'(1) << step_ff;
      quo_in   = ge ? (quo_ff | bit_mask[ConfW-1:0]) : quo_ff;
   end

   // Sequencer: setup, multiply by 100, up to eight quotient steps (none for equal rates).
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         step_ff  <= '0;
      end else begin
         case (state_ff)
            D_IDLE: begin
               if (req.start) begin
                  is_a_ff <= dist_a <= dist_b;
                  dist_ff <= dist_in;
                  span_ff <= (req.rate_a >= req.rate_b) ? req.rate_a - req.rate_b
                                                        : req.rate_b - req.rate_a;
                  if (req.rate_a == req.rate_b) begin
                     conf_ff  <= ConfMax;
                     state_ff <= D_DONE;
                  end else begin
                     state_ff <= D_MUL;
                  end
               end
            end
            D_MUL: begin
               rem_ff   <= RemW'(dist_ff) * RemW'(ConfMax);
               quo_ff   <= '0;
               step_ff  <= 3'd7;
               state_ff <= D_DIV;
            end
            D_DIV: begin
               if (ge) begin
                  rem_ff <= rem_ff - shifted;
               end
               quo_ff <= quo_in;
               if (ge && (step_ff == 3'd7)) begin
                  // Quotient of 128 or more: cap straight away.
                  conf_ff  <= ConfMax;
                  state_ff <= D_DONE;
               end else if (step_ff == 3'd0) begin
                  conf_ff  <= (quo_in > ConfMax) ? ConfMax : quo_in;
                  state_ff <= D_DONE;
               end else begin
                  step_ff <= step_ff - 3'd1;
               end
            end
            D_DONE: begin
               state_ff <= D_IDLE;
            end
            default: begin
               state_ff <= D_IDLE;
            end
         endcase
      end
   end

   assign rsp.done       = (state_ff == D_DONE);
   assign rsp.is_class_a = is_a_ff;
   assign rsp.confidence = conf_ff;

   // A finished confidence never exceeds the cap.
   a_conf_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == D_DONE) |-> (conf_ff <= ConfMax))
      else $error("confidence above cap");

   // The multiply step always leads into the quotient steps from the top bit.
   a_mul_to_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == D_MUL) |=> (state_ff == D_DIV) && (step_ff == 3'd7))
      else $error("quotient steps did not start at the top bit");

endmodule

>>> design/gated_pulse_rate_classifier.sv
// ----------------------------------------------------------------------------
// gated_pulse_rate_classifier
// Debounced edge counter over a scan of timed windows, with a per-window
// result and a scan summary carrying class and confidence.
//
//   Channel | Direction | Ports               | Transaction
//   req     | in        | req_valid/req_stall | one microsecond tick
//   rsp     | out       | rsp_valid/rsp_stall | window result or scan summary
//   csr     | in        | csr_write_enable    | one register write
//
// A tick waits while a result is held or a summary is due.
// The tick that closes the scan latches the classifier operands; it then runs
// a multiply step, up to eight quotient steps on one shared subtract unit and
// a done state (only the done state for equal rates), and the summary then
// loads from the summary state, once the window result has been taken.
// Reset is synchronous, clears the scan and the sequencers and sets the registers to their defaults.
// ----------------------------------------------------------------------------
module gated_pulse_rate_classifier import gprc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_falling_edge,
   input  logic                req_start_scan,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_kind,
   output logic [IdxW-1:0]     rsp_window_index,
   output logic [WinW-1:0]     rsp_window_count,
   output logic [ScanW-1:0]    rsp_total_count,
   output logic                rsp_is_class_a,
   output logic [ConfW-1:0]    rsp_confidence,
   output logic                rsp_low_confidence,
   output logic                rsp_last,
   input  logic                csr_write_enable,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   typedef enum logic [1:0] {T_IDLE, T_CALC, T_SUMMARY} top_state_type;

   top_state_type      state_ff;
   logic [WinW-1:0]    window_ticks_ff;
   logic [NumWinW-1:0] num_windows_ff;
   logic [DebW-1:0]    debounce_ticks_ff;
   logic [RateW-1:0]   rate_a_ff;
   logic [RateW-1:0]   rate_b_ff;
   logic [ConfW-1:0]   low_conf_ff;
   logic [IdxW-1:0]    sum_index_ff;
   logic [ScanW-1:0]   sum_total_ff;

   logic               rsp_valid_ff;
   logic               rsp_kind_ff;
   logic [IdxW-1:0]    rsp_index_ff;
   logic [WinW-1:0]    rsp_wcount_ff;
   logic [ScanW-1:0]   rsp_total_ff;
   logic               rsp_class_a_ff;
   logic [ConfW-1:0]   rsp_conf_ff;
   logic               rsp_low_ff;
   logic               rsp_last_ff;

   logic               tick_take;
   logic               rsp_take;
   cnt_cfg_type        cnt_cfg;
   tick_info_type      info;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   // Handshakes.
   assign req_stall = (state_ff != T_IDLE) || rsp_valid_ff;
   assign tick_take = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ticks_ff   <= WinW'(200000);
         num_windows_ff    <= NumWinW'(5);
         debounce_ticks_ff <= DebW'(40);
         rate_a_ff         <= RateW'(547);
         rate_b_ff         <= RateW'(312);
         low_conf_ff       <= ConfW'(40);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WINDOW_TICKS:     window_ticks_ff   <= csr_wdata[WinW-1:0];
            CSR_NUM_WINDOWS:      num_windows_ff    <= csr_wdata[NumWinW-1:0];
            CSR_DEBOUNCE_TICKS:   debounce_ticks_ff <= csr_wdata[DebW-1:0];
            CSR_RATE_A:           rate_a_ff         <= csr_wdata[RateW-1:0];
            CSR_RATE_B:           rate_b_ff         <= csr_wdata[RateW-1:0];
            CSR_LOW_CONF_PERCENT: low_conf_ff       <= csr_wdata[ConfW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Counting datapath.
   assign cnt_cfg.window_ticks   = window_ticks_ff;
   assign cnt_cfg.num_windows    = num_windows_ff;
   assign cnt_cfg.debounce_ticks = debounce_ticks_ff;

   gprc_counter u_counter (
      .clock        (clock),
      .reset        (reset),
      .tick         (tick_take),
      .falling_edge (req_falling_edge),
      .start_scan   (req_start_scan),
      .cfg          (cnt_cfg),
      .info         (info)
   );

   // Classifier starts on the tick that closes the scan.
   assign div_req.start  = tick_take && info.scan_done;
   assign div_req.total  = info.scan_total;
   assign div_req.rate_a = rate_a_ff;
   assign div_req.rate_b = rate_b_ff;

   gprc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The summary state reloads the register itself when it is taken.
         if (rsp_take && (state_ff != T_SUMMARY)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            T_IDLE: begin
               if (tick_take && info.win_done) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_kind_ff    <= 1'b0;
                  rsp_index_ff   <= info.win_index;
                  rsp_wcount_ff  <= info.win_count;
                  rsp_total_ff   <= info.scan_total;
                  rsp_class_a_ff <= 1'b0;
                  rsp_conf_ff    <= '0;
                  rsp_low_ff     <= 1'b0;
                  rsp_last_ff    <= 1'b0;
                  if (info.scan_done) begin
                     sum_index_ff <= info.win_index;
                     sum_total_ff <= info.scan_total;
                     state_ff     <= T_CALC;
                  end
               end
            end
            T_CALC: begin
               if (div_rsp.done) begin
                  state_ff <= T_SUMMARY;
               end
            end
            T_SUMMARY: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_kind_ff    <= 1'b1;
                  rsp_index_ff   <= sum_index_ff;
                  rsp_wcount_ff  <= '0;
                  rsp_total_ff   <= sum_total_ff;
                  rsp_class_a_ff <= div_rsp.is_class_a;
                  rsp_conf_ff    <= div_rsp.confidence;
                  rsp_low_ff     <= div_rsp.confidence < low_conf_ff;
                  rsp_last_ff    <= 1'b1;
                  state_ff       <= T_IDLE;
               end
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_window_index   = rsp_index_ff;
   assign rsp_window_count   = rsp_wcount_ff;
   assign rsp_total_count    = rsp_total_ff;
   assign rsp_is_class_a     = rsp_class_a_ff;
   assign rsp_confidence     = rsp_conf_ff;
   assign rsp_low_confidence = rsp_low_ff;
   assign rsp_last           = rsp_last_ff;

   // The tick that closes a scan hands off to the classifier.
   a_scan_to_calc: assert property (@(posedge clock) disable iff (reset)
      (tick_take && info.scan_done) |=> (state_ff == T_CALC) && rsp_valid_ff)
      else $error("scan end did not start classification");

   // The classifier only finishes while the sequencer waits for it.
   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == T_CALC))
      else $error("classifier result outside of calculation");

   // A summary transaction always carries the last flag and a capped confidence.
   a_summary_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff) |-> (rsp_last_ff && (rsp_conf_ff <= ConfMax)))
      else $error("malformed summary transaction");

endmodule

>>> sim/scan_result_monitor.sv
// ----------------------------------------------------------------------------
// scan_result_monitor
// Watches the tick, result and register ports of the pulse-rate classifier.
// It keeps its own copy of the registers and of the scan state. It works out
// the window and summary results that each accepted tick should cause, and
// compares every accepted result, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module scan_result_monitor import gprc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                req_falling_edge,
   input  logic                req_start_scan,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic                rsp_kind,
   input  logic [IdxW-1:0]     rsp_window_index,
   input  logic [WinW-1:0]     rsp_window_count,
   input  logic [ScanW-1:0]    rsp_total_count,
   input  logic                rsp_is_class_a,
   input  logic [ConfW-1:0]    rsp_confidence,
   input  logic                rsp_low_confidence,
   input  logic                rsp_last,
   input  logic                csr_write_enable,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output int                  fail_count,
   output int                  results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic KindWindow  = 1'b0;
   localparam logic KindSummary = 1'b1;
   localparam longint PercentFull = 100;

   typedef struct packed {
      logic              kind;
      logic [IdxW-1:0]   window_index;
      logic [WinW-1:0]   window_count;
      logic [ScanW-1:0]  total_count;
      logic              is_class_a;
      logic [ConfW-1:0]  confidence;
      logic              low_confidence;
      logic              last;
   } scan_result_type;

   // Register copies.
   logic [WinW-1:0]    window_ticks;
   logic [NumWinW-1:0] num_windows;
   logic [DebW-1:0]    debounce_ticks;
   logic [RateW-1:0]   rate_a;
   logic [RateW-1:0]   rate_b;
   logic [ConfW-1:0]   low_conf_percent;

   // Scan state. The window number needs one bit more than the index so
   // that a full scan of sixteen windows does not wrap.
   logic               scanning;
   logic [WinW-1:0]    tick_in_window;
   logic [IdxW:0]      window_number;
   logic [WinW-1:0]    edges_in_window;
   logic [ScanW-1:0]   edges_in_scan;
   logic [SinceW-1:0]  since_edge;

   scan_result_type scan_results_q[$];
   int failures = 0;

   // Percent distance of the total from the midpoint of the two rates,
   // relative to half their span, capped at full.
   function automatic logic [ConfW-1:0] scan_confidence(input logic [ScanW-1:0] total,
                                                        input logic [RateW-1:0] ra,
                                                        input logic [RateW-1:0] rb);
      longint dist_abs, span, pct;
      if (ra == rb) begin
         return ConfW'(PercentFull);
      end
      dist_abs = 2 * longint'(total) - longint'(ra) - longint'(rb);
      if (dist_abs < 0) dist_abs = -dist_abs;
      span = (ra > rb) ? longint'(ra) - longint'(rb) : longint'(rb) - longint'(ra);
      pct = dist_abs * PercentFull / span;
      if (pct > PercentFull) pct = PercentFull;
      return ConfW'(pct);
   endfunction

   // One tick: debounce first, then count and close windows and the scan.
   task automatic advance_tick(input logic fall_in, input logic start_in);
      logic            taken;
      logic [WinW-1:0] wt_eff;
      longint          nw_eff, da, db;
      scan_result_type r;
      if (since_edge < SinceW'(256)) since_edge++;
      taken = fall_in && (since_edge > SinceW'(debounce_ticks));
      if (taken) since_edge = '0;

      if (!scanning && start_in) begin
         scanning = 1'b1;
         tick_in_window = '0;
         window_number = '0;
         edges_in_window = '0;
         edges_in_scan = '0;
      end
      if (!scanning) return;

      if (taken) begin
         if (edges_in_window != '1) edges_in_window++;
         if (edges_in_scan != '1) edges_in_scan++;
      end
      tick_in_window++;
      wt_eff = (window_ticks == '0) ? WinW'(1) : window_ticks;
      if (tick_in_window < wt_eff) return;

      r = '0;
      r.kind = KindWindow;
      r.window_index = window_number[IdxW-1:0];
      r.window_count = edges_in_window;
      r.total_count = edges_in_scan;
      scan_results_q.push_back(r);
      tick_in_window = '0;
      edges_in_window = '0;
      window_number++;

      nw_eff = (num_windows == '0) ? 1 : longint'(num_windows);
      if (nw_eff > MaxWindows) nw_eff = MaxWindows;
      if (longint'(window_number) >= nw_eff) begin
         da = longint'(edges_in_scan) - longint'(rate_a);
         db = longint'(edges_in_scan) - longint'(rate_b);
         if (da < 0) da = -da;
         if (db < 0) db = -db;
         r = '0;
         r.kind = KindSummary;
         r.window_index = IdxW'(window_number - 1'b1);
         r.total_count = edges_in_scan;
         r.is_class_a = (da <= db);
         r.confidence = scan_confidence(edges_in_scan, rate_a, rate_b);
         r.low_confidence = (r.confidence < low_conf_percent);
         r.last = 1'b1;
         scan_results_q.push_back(r);
         scanning = 1'b0;
         window_number = '0;
      end
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // Registers first, then the tick, then the result taken at this edge.
   always @(posedge clock) begin
      scan_result_type due;
      if (reset) begin
         window_ticks = WinW'(200000);
         num_windows = NumWinW'(5);
         debounce_ticks = DebW'(40);
         rate_a = RateW'(547);
         rate_b = RateW'(312);
         low_conf_percent = ConfW'(40);
         scanning = 1'b0;
         tick_in_window = '0;
         window_number = '0;
         edges_in_window = '0;
         edges_in_scan = '0;
         since_edge = '0;
         scan_results_q.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_WINDOW_TICKS:     window_ticks = csr_wdata[WinW-1:0];
               CSR_NUM_WINDOWS:      num_windows = csr_wdata[NumWinW-1:0];
               CSR_DEBOUNCE_TICKS:   debounce_ticks = csr_wdata[DebW-1:0];
               CSR_RATE_A:           rate_a = csr_wdata[RateW-1:0];
               CSR_RATE_B:           rate_b = csr_wdata[RateW-1:0];
               CSR_LOW_CONF_PERCENT: low_conf_percent = csr_wdata[ConfW-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            advance_tick(req_falling_edge, req_start_scan);
         end
         if (rsp_valid && !rsp_stall) begin
            if (scan_results_q.size() == 0) begin
               $error("result transaction with nothing due: kind %0d, index %0d, total %0d",
                      rsp_kind, rsp_window_index, rsp_total_count);
               failures++;
            end else begin
               due = scan_results_q.pop_front();
               check_field("kind", due.kind, rsp_kind);
               check_field("window_index", due.window_index, rsp_window_index);
               check_field("window_count", due.window_count, rsp_window_count);
               check_field("total_count", due.total_count, rsp_total_count);
               check_field("is_class_a", due.is_class_a, rsp_is_class_a);
               check_field("confidence", due.confidence, rsp_confidence);
               check_field("low_confidence", due.low_confidence, rsp_low_confidence);
               check_field("last", due.last, rsp_last);
            end
         end
      end
      fail_count <= failures;
      results_pending <= scan_results_q.size();
   end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives ticks and register writes into the pulse-rate classifier and stalls
// its result channel. A short directed part covers the register extremes,
// the zero and oversize window settings, equal rates and debounce limits;
// random phases with random settings follow. The monitor does all checking.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import gprc_pkg::*;

   localparam logic [CsrIdxW-1:0] CsrSpareLo = 3'd6;
   localparam logic [CsrIdxW-1:0] CsrSpareHi = 3'd7;
   localparam int SettleCycles = 32;
   localparam int unsigned CycleLimit = 600000;
   localparam int RandomPhases = 7;
   localparam int PhaseTicks = 210;

   typedef enum int {STALL_NONE, STALL_SCATTER, STALL_RUNS} stall_mode_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_falling_edge = 1'b0;
   logic                req_start_scan = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_kind;
   logic [IdxW-1:0]     rsp_window_index;
   logic [WinW-1:0]     rsp_window_count;
   logic [ScanW-1:0]    rsp_total_count;
   logic                rsp_is_class_a;
   logic [ConfW-1:0]    rsp_confidence;
   logic                rsp_low_confidence;
   logic                rsp_last;
   logic                csr_write_enable = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;
   int                  fail_count;
   int                  results_pending;

   int             gap_limit = 0;
   int             burst_left = 0;
   int unsigned    cycle_count = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;
   int             stall_run = 0;

   gated_pulse_rate_classifier dut (.*);
   scan_result_monitor monitor (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Run watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver stalls: the pattern switches between none, scattered single
   // cycles and longer runs.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         mode_left = $urandom_range(32, 256);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_SCATTER: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: begin
            if (stall_run > 0) begin
               stall_run--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
               if ($urandom_range(0, 5) == 0) stall_run = $urandom_range(1, 8);
            end
         end
      endcase
   end

   // One tick transaction. Bursts of random length, with a random gap
   // before each burst when gaps are enabled.
   task automatic send_tick(input logic fall_in, input logic start_in);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gap_limit > 0) gap = $urandom_range(0, gap_limit);
      end
      burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_falling_edge <= fall_in;
      req_start_scan <= start_in;
      do @(posedge clock); while (req_stall);
   endtask

   // Bits above the register width carry random junk.
   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input int unsigned value,
                            input int width);
      logic [CsrDataW-1:0] keep;
      keep = CsrDataW'((64'd1 << width) - 1);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= (CsrDataW'($urandom) & ~keep) | (CsrDataW'(value) & keep);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic load_settings(input int unsigned wt, input int unsigned nw,
                                input int unsigned deb, input int unsigned ra,
                                input int unsigned rb, input int unsigned lc);
      write_reg(CSR_WINDOW_TICKS, wt, WinW);
      write_reg(CSR_NUM_WINDOWS, nw, NumWinW);
      write_reg(CSR_DEBOUNCE_TICKS, deb, DebW);
      write_reg(CSR_RATE_A, ra, RateW);
      write_reg(CSR_RATE_B, rb, RateW);
      write_reg(CSR_LOW_CONF_PERCENT, lc, ConfW);
   endtask

   // Finish any open scan with plain ticks, then let every result drain
   // and the classifier go quiet.
   task automatic settle(input int drain_ticks);
      repeat (drain_ticks) send_tick($urandom_range(0, 1), 1'b0);
      @(negedge clock);
      req_valid <= 1'b0;
      wait (results_pending == 0);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic random_phase();
      int unsigned wt, nw, deb, ra, rb, lc, reach, fall_odds, wt_eff, nw_eff;
      wt = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
      nw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
      deb = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
      wt_eff = (wt == 0) ? 1 : wt;
      nw_eff = (nw == 0) ? 1 : ((nw > MaxWindows) ? MaxWindows : nw);
      reach = wt_eff * nw_eff + 2;
      case ($urandom_range(0, 3))
         0: begin
            ra = $urandom_range(0, reach);
            rb = ra;
         end
         3: begin
            ra = $urandom_range(0, 65535);
            rb = $urandom_range(0, 65535);
         end
         default: begin
            ra = $urandom_range(0, reach);
            rb = $urandom_range(0, reach);
         end
      endcase
      lc = $urandom_range(0, 100);
      fall_odds = $urandom_range(1, 15);
      case ($urandom_range(0, 2))
         0: gap_limit = 0;
         1: gap_limit = 3;
         default: gap_limit = 10;
      endcase
      load_settings(wt, nw, deb, ra, rb, lc);
      // Starts come often, so scans follow one another closely.
      repeat (PhaseTicks) begin
         send_tick($urandom_range(0, 15) < fall_odds, $urandom_range(0, 3) == 0);
      end
      settle(wt_eff * nw_eff);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Short windows, equal rates, back-to-back edges with no debounce,
      // a start request while scanning.
      gap_limit = 0;
      load_settings(3, 2, 0, 10, 10, 100);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b0);
      settle(0);

      // Zero window length and zero window count, widest debounce,
      // rates at opposite extremes.
      load_settings(0, 0, 255, 0, 65535, 0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      settle(0);

      // Window count above the maximum, one-tick windows, total at the
      // midpoint of the rates.
      load_settings(1, 31, 1, 16, 0, 100);
      send_tick(1'b1, 1'b1);
      repeat (15) send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      settle(0);

      // Writes to unused register indexes must change nothing.
      write_reg(CsrSpareLo, $urandom, CsrDataW);
      write_reg(CsrSpareHi, $urandom, CsrDataW);

      // Longest window: no scan is started, only debouncing runs.
      load_settings(24'hFFFFFF, 16, $urandom_range(0, 7), 65535, 65535, 100);
      gap_limit = 3;
      repeat (40) send_tick($urandom_range(0, 1), 1'b0);
      settle(0);

      repeat (RandomPhases) random_phase();

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
